// ----- sv/i2c_rrs_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C register read sequencer package
// Shared types and constants: event codes, phases and register indexes.
// ----------------------------------------------------------------------------
package i2c_rrs_pkg;

	localparam int unsigned CfgIndexWidth = 2;
	localparam int unsigned CfgDataWidth  = 8;
	localparam int unsigned CountWidth    = 4;

	localparam logic [CountWidth-1:0] RetryLimitReset = 4'd3;
	localparam logic [7:0]            ReadBit         = 8'h01;

	typedef enum logic [1:0] {
		MODE_READ    = 2'd0,
		MODE_IRQ     = 2'd1,
		MODE_DELIVER = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [CfgIndexWidth-1:0] {
		REG_SLAVE_ADDR  = 2'd0,
		REG_INDEX       = 2'd1,
		REG_RETRY_LIMIT = 2'd2
	} cfg_reg_t;

	typedef enum logic [6:0] {
		PH_IDLE  = 7'b0000001,
		PH_ADDR  = 7'b0000010,
		PH_REG   = 7'b0000100,
		PH_RDAD  = 7'b0001000,
		PH_DUMMY = 7'b0010000,
		PH_HIGH  = 7'b0100000,
		PH_DONE  = 7'b1000000
	} phase_t;

endpackage

// ----- sv/i2c_register_read_sequencer.sv -----
// ----------------------------------------------------------------------------
// I2C register read sequencer
// Steps an I2C master through a two-byte register read with repeated start.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   mode, irq_flag, arbitration_lost, rx_byte
// output    out        out_valid/out_stall one result per request
// config    in         cfg_write           cfg_index, cfg_data
//
// An accepted request is loaded into the input register, and the sequencing
// logic then runs from it into the result register once that register can advance.
// A new request is accepted every cycle while results are taken.
// While a result waits, the input register takes one more request and then
// in_stall stays high until the result is taken.
// Reset clears the phase, the retry count, the stored bytes and the control bits.
// ----------------------------------------------------------------------------
module i2c_register_read_sequencer
	import i2c_rrs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     cfg_write,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data,

	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               mode,
	input  logic                     irq_flag,
	input  logic                     arbitration_lost,
	input  logic [7:0]               rx_byte,

	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     request_accepted,
	output logic                     tx_valid,
	output logic [7:0]               tx_byte,
	output logic                     master_mode,
	output logic                     transmit_mode,
	output logic                     no_ack_on_rx,
	output logic                     repeat_start,
	output logic                     value_valid,
	output logic [15:0]              value,
	output logic                     read_failed,
	output logic                     busy_abort,
	output logic                     unexpected_irq
);

	logic [7:0]            slave_addr_q;
	logic [7:0]            reg_index_q;
	logic [CountWidth-1:0] retry_limit_q;

	phase_t                phase_q;
	logic [CountWidth-1:0] busy_count_q;
	logic [7:0]            high_byte_q;
	logic [7:0]            low_byte_q;
	logic                  master_q;
	logic                  transmit_q;
	logic                  noack_q;

	logic                  valid_s1;
	mode_t                 mode_s1;
	logic                  irq_s1;
	logic                  arb_s1;
	logic [7:0]            rx_s1;

	logic                  out_valid_q;
	logic                  accepted_q;
	logic                  tx_valid_q;
	logic [7:0]            tx_byte_q;
	logic                  rsta_q;
	logic                  value_valid_q;
	logic [15:0]           value_q;
	logic                  failed_q;
	logic                  babort_q;
	logic                  unexp_q;

	logic                  advance;
	logic                  step;

	phase_t                phase_d;
	logic [CountWidth-1:0] busy_count_d;
	logic [CountWidth-1:0] busy_inc;
	logic [7:0]            high_byte_d;
	logic [7:0]            low_byte_d;
	logic                  master_d;
	logic                  transmit_d;
	logic                  noack_d;
	logic                  accepted_d;
	logic                  tx_valid_d;
	logic [7:0]            tx_byte_d;
	logic                  rsta_d;
	logic                  value_valid_d;
	logic [15:0]           value_d;
	logic                  failed_d;
	logic                  babort_d;
	logic                  unexp_d;

	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign busy_inc = busy_count_q + {{(CountWidth-1){1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q  <= '0;
			reg_index_q   <= '0;
			retry_limit_q <= RetryLimitReset;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SLAVE_ADDR:  slave_addr_q  <= cfg_data;
				REG_INDEX:       reg_index_q   <= cfg_data;
				REG_RETRY_LIMIT: retry_limit_q <= cfg_data[CountWidth-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d       = phase_q;
		busy_count_d  = busy_count_q;
		high_byte_d   = high_byte_q;
		low_byte_d    = low_byte_q;
		master_d      = master_q;
		transmit_d    = transmit_q;
		noack_d       = noack_q;
		accepted_d    = 1'b0;
		tx_valid_d    = 1'b0;
		tx_byte_d     = '0;
		rsta_d        = 1'b0;
		value_valid_d = 1'b0;
		value_d       = '0;
		failed_d      = 1'b0;
		babort_d      = 1'b0;
		unexp_d       = 1'b0;

		case (mode_s1)
			MODE_READ: begin
				if (phase_q == PH_IDLE) begin
					busy_count_d = '0;
					phase_d      = PH_ADDR;
					master_d     = 1'b1;
					transmit_d   = 1'b1;
					tx_valid_d   = 1'b1;
					tx_byte_d    = slave_addr_q;
					accepted_d   = 1'b1;
				end else if (busy_inc >= retry_limit_q) begin
					master_d     = 1'b0;
					transmit_d   = 1'b0;
					noack_d      = 1'b0;
					phase_d      = PH_IDLE;
					busy_count_d = '0;
					babort_d     = 1'b1;
				end else begin
					busy_count_d = busy_inc;
				end
			end
			MODE_IRQ: begin
				if (arb_s1) begin
					master_d   = 1'b0;
					transmit_d = 1'b0;
					noack_d    = 1'b0;
					phase_d    = PH_IDLE;
					failed_d   = 1'b1;
				end else if (irq_s1 && !(phase_q inside {PH_IDLE, PH_DONE})) begin
					case (phase_q)
						PH_ADDR: begin
							phase_d    = PH_REG;
							tx_valid_d = 1'b1;
							tx_byte_d  = reg_index_q;
						end
						PH_REG: begin
							phase_d    = PH_RDAD;
							rsta_d     = 1'b1;
							tx_valid_d = 1'b1;
							tx_byte_d  = slave_addr_q | ReadBit;
						end
						PH_RDAD: begin
							phase_d     = PH_DUMMY;
							transmit_d  = 1'b0;
							noack_d     = 1'b0;
							high_byte_d = rx_s1;
						end
						PH_DUMMY: begin
							phase_d     = PH_HIGH;
							noack_d     = 1'b1;
							high_byte_d = rx_s1;
						end
						PH_HIGH: begin
							phase_d    = PH_DONE;
							master_d   = 1'b0;
							transmit_d = 1'b0;
							noack_d    = 1'b0;
							low_byte_d = rx_s1;
						end
						default: ;
					endcase
				end else begin
					unexp_d = 1'b1;
				end
			end
			MODE_DELIVER: begin
				value_valid_d = 1'b1;
				value_d       = {high_byte_q, low_byte_q};
				phase_d       = PH_IDLE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			mode_s1 <= mode_t'(mode);
			irq_s1  <= irq_flag;
			arb_s1  <= arbitration_lost;
			rx_s1   <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			busy_count_q <= '0;
			high_byte_q  <= '0;
			low_byte_q   <= '0;
			master_q     <= 1'b0;
			transmit_q   <= 1'b0;
			noack_q      <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			busy_count_q <= busy_count_d;
			high_byte_q  <= high_byte_d;
			low_byte_q   <= low_byte_d;
			master_q     <= master_d;
			transmit_q   <= transmit_d;
			noack_q      <= noack_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			accepted_q    <= accepted_d;
			tx_valid_q    <= tx_valid_d;
			tx_byte_q     <= tx_byte_d;
			rsta_q        <= rsta_d;
			value_valid_q <= value_valid_d;
			value_q       <= value_d;
			failed_q      <= failed_d;
			babort_q      <= babort_d;
			unexp_q       <= unexp_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign request_accepted = accepted_q;
	assign tx_valid         = tx_valid_q;
	assign tx_byte          = tx_byte_q;
	assign master_mode      = master_q;
	assign transmit_mode    = transmit_q;
	assign no_ack_on_rx     = noack_q;
	assign repeat_start     = rsta_q;
	assign value_valid      = value_valid_q;
	assign value            = value_q;
	assign read_failed      = failed_q;
	assign busy_abort       = babort_q;
	assign unexpected_irq   = unexp_q;

	// The phase register always holds exactly one phase.
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("phase register is not one-hot");

	// A started transaction sends the address with master and transmit held.
	a_start_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && request_accepted) |-> (tx_valid && master_mode && transmit_mode))
		else $error("accepted request without address byte and control bits");

	// An abort always releases the bus.
	a_abort_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (busy_abort || read_failed)) |->
		(!master_mode && !transmit_mode && !no_ack_on_rx))
		else $error("abort left control bits set");

	// A held request in the input register is stalled while the result waits.
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && out_stall) |-> in_stall)
		else $error("input accepted while both stages are full and stalled");

endmodule
